// ===== hdl/dbc_pkg.sv =====
// Package for the multichannel retrigger debouncer.
// Widths, register indexes, reset values and the shared structs; no dependencies.
`default_nettype none

package dbc_pkg;

	localparam int CHANNELS = 16;
	localparam int PIN_W    = 16;
	// channels that can ever be active: limited by the pin field
	localparam int ACT_MAX  = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

	localparam int CNT_W    = 5;
	localparam int DEB_W    = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = CNT_W'(16);
	localparam logic [DEB_W-1:0] RST_DEBOUNCE      = DEB_W'(20);

	typedef enum logic [1:0] {
		REG_CHANNEL_COUNT  = 2'd0,
		REG_INVERT_MASK    = 2'd1,
		REG_DEBOUNCE_TICKS = 2'd2,
		REG_EDGE_ENABLE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] channel_count;
		logic [PIN_W-1:0] invert_mask;
		logic [DEB_W-1:0] debounce_ticks;
		logic             edge_enable;
	} cfg_t;

	// common control for every channel slice
	typedef struct packed {
		logic             step;
		logic             primed;
		logic             edge_en;
		logic [DEB_W-1:0] debounce;
	} chan_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/multichannel_retrigger_debouncer.sv =====
// Top level of the multichannel retrigger debouncer.
// Uses dbc_pkg, dbc_regs and dbc_chan.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------
//  input    | in_valid/in_stall  | raw_pins
//  output   | out_valid/out_stall| levels, changed_mask
//  config   | APB-style          | paddr, pwdata, prdata
//
// One item per cycle unless the output stalls.
// Each item: input register, one pass of per-channel logic, result register, output.
// Reset clears all channel state, the priming flag and the registers to defaults.
// A stalled output holds its item; the input stage stalls only while full and blocked.
`default_nettype none

module multichannel_retrigger_debouncer
	import dbc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [PIN_W-1:0]  raw_pins,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [PIN_W-1:0]  levels,
	output logic      [PIN_W-1:0]  changed_mask,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t             cfg;
	logic             vld_s1;
	logic [PIN_W-1:0] raw_s1;
	logic             adv;
	logic             primed_q;
	logic [PIN_W-1:0] prev_raw_q;
	logic [CNT_W-1:0] n_act;
	logic [PIN_W-1:0] act;
	logic [PIN_W-1:0] logical;
	logic [PIN_W-1:0] edges;
	logic [PIN_W-1:0] lvl_nxt;
	logic [PIN_W-1:0] chg_nxt;
	chan_ctl_t        ctl;
	logic             out_valid_q;
	logic [PIN_W-1:0] levels_q;
	logic [PIN_W-1:0] changed_q;

	dbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// s1 item moves to the result register when that is empty or being taken
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1 <= raw_pins;
		end
	end

	assign n_act = (cfg.channel_count > CNT_W'(ACT_MAX)) ? CNT_W'(ACT_MAX)
		: cfg.channel_count;

	always_comb begin
		for (int i = 0; i < PIN_W; i++) begin
			act[i] = (CNT_W'(i) < n_act);
		end
	end

	assign logical = (raw_s1 ^ cfg.invert_mask) & act;
	assign edges   = (raw_s1 ^ prev_raw_q) & act;

	assign ctl.step     = vld_s1 && adv;
	assign ctl.primed   = primed_q;
	assign ctl.edge_en  = cfg.edge_enable;
	assign ctl.debounce = cfg.debounce_ticks;

	for (genvar g = 0; g < PIN_W; g++) begin : g_ch
		if (g < ACT_MAX) begin : g_live
			dbc_chan u_chan (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.active    (act[g]),
				.raw_edge  (edges[g]),
				.logical   (logical[g]),
				.level_nxt (lvl_nxt[g]),
				.chg_nxt   (chg_nxt[g])
			);
		end else begin : g_dead
			assign lvl_nxt[g] = 1'b0;
			assign chg_nxt[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			prev_raw_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= vld_s1;
			end
			if (ctl.step) begin
				primed_q   <= 1'b1;
				prev_raw_q <= raw_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			levels_q  <= lvl_nxt;
			changed_q <= chg_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign levels       = levels_q;
	assign changed_mask = changed_q;

endmodule

`default_nettype wire

// ===== hdl/dbc_regs.sv =====
// Configuration register file with APB-style access.
// Uses dbc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module dbc_regs
	import dbc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count  <= RST_CHANNEL_COUNT;
			cfg_q.invert_mask    <= '0;
			cfg_q.debounce_ticks <= RST_DEBOUNCE;
			cfg_q.edge_enable    <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_CHANNEL_COUNT:  cfg_q.channel_count  <= pwdata[CNT_W-1:0];
				REG_INVERT_MASK:    cfg_q.invert_mask    <= pwdata[PIN_W-1:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= pwdata[DEB_W-1:0];
				REG_EDGE_ENABLE:    cfg_q.edge_enable    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_CHANNEL_COUNT:  prdata[CNT_W-1:0] = cfg_q.channel_count;
			REG_INVERT_MASK:    prdata[PIN_W-1:0] = cfg_q.invert_mask;
			REG_DEBOUNCE_TICKS: prdata[DEB_W-1:0] = cfg_q.debounce_ticks;
			REG_EDGE_ENABLE:    prdata[0]         = cfg_q.edge_enable;
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/dbc_chan.sv =====
// One debounce channel: retriggerable countdown and stored level.
// Uses dbc_pkg for chan_ctl_t and widths.
`default_nettype none

module dbc_chan
	import dbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire chan_ctl_t ctl,
	input  wire logic      active,
	input  wire logic      raw_edge,
	input  wire logic      logical,
	output logic           level_nxt,
	output logic           chg_nxt
);

	logic [DEB_W-1:0] count_q;
	logic [DEB_W-1:0] count_nxt;
	logic             level_q;
	logic             eval;

	always_comb begin
		count_nxt = count_q;
		level_nxt = level_q;
		chg_nxt   = 1'b0;
		eval      = 1'b0;
		if (!active) begin
			count_nxt = '0;
			level_nxt = 1'b0;
		end else if (!ctl.primed) begin
			level_nxt = logical;
		end else begin
			if (ctl.edge_en && raw_edge) begin
				count_nxt = ctl.debounce;
				eval      = (ctl.debounce == '0);
			end else if (count_q != '0) begin
				count_nxt = count_q - DEB_W'(1);
				eval      = (count_q == DEB_W'(1));
			end
			if (eval && (logical != level_q)) begin
				level_nxt = logical;
				chg_nxt   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			level_q <= 1'b0;
		end else if (ctl.step) begin
			count_q <= count_nxt;
			level_q <= level_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_multichannel_retrigger_debouncer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_retrigger_debouncer: directed and random tick streams.
// Needs dbc_pkg and the RTL top; a built-in tick predictor checks every result item.

module tb_multichannel_retrigger_debouncer;
	import dbc_pkg::*;

	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 157;
	localparam int LONG_HOLD   = 200;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic [PIN_W-1:0] levels;
		logic [PIN_W-1:0] changed;
	} tick_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PIN_W-1:0]  raw_pins = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PIN_W-1:0]  levels;
	logic [PIN_W-1:0]  changed_mask;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	multichannel_retrigger_debouncer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .raw_pins(raw_pins),
		.out_valid(out_valid), .out_stall(out_stall),
		.levels(levels), .changed_mask(changed_mask),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor copy of the registers and channel state
	logic [CNT_W-1:0] cfg_count   = RST_CHANNEL_COUNT;
	logic [PIN_W-1:0] cfg_invert  = '0;
	logic [DEB_W-1:0] cfg_debounce = RST_DEBOUNCE;
	logic             cfg_edge_en = 1'b1;
	logic             primed = 1'b0;
	logic [PIN_W-1:0] last_raw = '0;
	logic [PIN_W-1:0] stable = '0;
	logic [DEB_W-1:0] ticks_left [ACT_MAX];

	tick_result_t due_levels[$];

	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_changes = 0;
	int n_writes = 0;
	int input_stall_cycles = 0;

	// receiver stall pattern, steered by the tests
	int stall_pct = 0;
	int long_hold_req = 0;
	int long_hold_done = 0;
	int hold_left = 0;
	int run_left = 0;
	bit run_on = 1'b0;

	initial for (int i = 0; i < ACT_MAX; i++) ticks_left[i] = '0;

	function automatic tick_result_t debounce_tick(input logic [PIN_W-1:0] raw);
		tick_result_t res;
		int n;
		logic [PIN_W-1:0] act;
		logic [PIN_W-1:0] logical;
		logic [PIN_W-1:0] edges;
		bit evaluate;
		n = (int'(cfg_count) > ACT_MAX) ? ACT_MAX : int'(cfg_count);
		act = (n >= PIN_W) ? '1 : PIN_W'((32'd1 << n) - 1);
		logical = (raw ^ cfg_invert) & act;
		res.changed = '0;
		for (int i = n; i < ACT_MAX; i++) ticks_left[i] = '0;
		stable &= act;
		if (!primed) begin
			primed = 1'b1;
			stable = logical;
		end else begin
			edges = (raw ^ last_raw) & act;
			for (int i = 0; i < n; i++) begin
				evaluate = 1'b0;
				if (cfg_edge_en && edges[i]) begin
					ticks_left[i] = cfg_debounce;
					evaluate = (ticks_left[i] == '0);
				end else if (ticks_left[i] != '0) begin
					ticks_left[i] = ticks_left[i] - 1'b1;
					evaluate = (ticks_left[i] == '0);
				end
				if (evaluate && (logical[i] != stable[i])) begin
					stable[i] = logical[i];
					res.changed[i] = 1'b1;
				end
			end
		end
		last_raw = raw;
		res.levels = stable;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// result checker
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && in_valid && in_stall)
			input_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (due_levels.size() == 0) begin
				report_mismatch($sformatf("unexpected item levels=%h changed=%h",
					levels, changed_mask));
			end else begin
				want = due_levels.pop_front();
				n_results++;
				if (want.changed != '0)
					n_changes++;
				if (levels !== want.levels)
					report_mismatch($sformatf("levels got %h want %h", levels, want.levels));
				if (changed_mask !== want.changed)
					report_mismatch($sformatf("changed_mask got %h want %h",
						changed_mask, want.changed));
			end
		end
	end

	// receiver: random stall runs, plus a long hold when a test asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (long_hold_done != long_hold_req) begin
			long_hold_done = long_hold_req;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_left = $urandom_range(1, 12);
				run_on = ($urandom_range(1, 100) <= stall_pct);
			end
			run_left--;
			out_stall <= run_on;
		end
	end

	task automatic send_tick(input logic [PIN_W-1:0] r);
		in_valid <= 1'b1;
		raw_pins <= r;
		do @(posedge clk); while (in_stall);
		due_levels.push_back(debounce_tick(r));
		n_items++;
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_levels.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		wait_drained();
		repeat (3) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHANNEL_COUNT:  cfg_count = val[CNT_W-1:0];
			REG_INVERT_MASK:    cfg_invert = val[PIN_W-1:0];
			REG_DEBOUNCE_TICKS: cfg_debounce = val[DEB_W-1:0];
			REG_EDGE_ENABLE:    cfg_edge_en = val[0];
			default: ;
		endcase
		n_writes++;
	endtask

	// mostly held pins with sparse bounces, some pure noise
	function automatic logic [PIN_W-1:0] next_raw(input logic [PIN_W-1:0] prev);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return prev;
		else if (pick < 90)
			return prev ^ PIN_W'($urandom & $urandom & $urandom);
		else
			return PIN_W'($urandom);
	endfunction

	task automatic test_priming();
		send_tick(16'hA5A5);
		send_tick(16'hA5A5);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
	endtask

	task automatic test_zero_debounce();
		write_reg(REG_DEBOUNCE_TICKS, 32'd0);
		write_reg(REG_INVERT_MASK, 32'hFFFF);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		send_tick(16'h5A5A);
	endtask

	task automatic test_retrigger();
		write_reg(REG_INVERT_MASK, 32'h0);
		write_reg(REG_DEBOUNCE_TICKS, 32'd2);
		send_tick(16'h0001);
		send_tick(16'h0001);
		send_tick(16'h0000);  // edge restarts channel 0
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0000);
	endtask

	task automatic test_edges_disabled();
		write_reg(REG_DEBOUNCE_TICKS, 32'd3);
		send_tick(16'h000F);
		// countdowns already running must still expire
		write_reg(REG_EDGE_ENABLE, 32'd0);
		send_tick(16'h0000);
		send_tick(16'h000F);
		send_tick(16'h0000);
		send_tick(16'h000F);
		write_reg(REG_EDGE_ENABLE, 32'd1);
	endtask

	task automatic test_channel_count();
		write_reg(REG_DEBOUNCE_TICKS, 32'd0);
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		send_tick(16'hFFFF);
		send_tick(16'h0000);
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		send_tick(16'hFFFF);
		write_reg(REG_CHANNEL_COUNT, 32'd31);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		write_reg(REG_CHANNEL_COUNT, 32'd8);
		send_tick(16'h00FF);
		// upper channels come back with level 0
		write_reg(REG_CHANNEL_COUNT, 32'd16);
		send_tick(16'hFFFF);
	endtask

	task automatic test_backpressure();
		logic [PIN_W-1:0] r;
		stall_pct = 0;
		write_reg(REG_DEBOUNCE_TICKS, 32'd1);
		r = 16'h0F0F;
		long_hold_req++;
		for (int i = 0; i < 40; i++) begin
			r = next_raw(r);
			send_tick(r);
		end
		wait_drained();
	endtask

	task automatic test_random_phase(input int idx);
		logic [PIN_W-1:0] r;
		int burst_left;
		bit steady;
		logic [DATA_W-1:0] cnt_val;
		logic [DATA_W-1:0] deb_val;
		case (idx % 6)
			0: begin cnt_val = 16; deb_val = 0; end
			1: begin cnt_val = 31; deb_val = 1; end
			2: begin cnt_val = 1; deb_val = 16'hFFFF; end
			3: begin cnt_val = 0; deb_val = $urandom_range(0, 6); end
			default: begin
				cnt_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, 16);
				deb_val = $urandom_range(0, 8);
			end
		endcase
		write_reg(REG_CHANNEL_COUNT, cnt_val);
		write_reg(REG_DEBOUNCE_TICKS, deb_val);
		case (idx % 3)
			0: write_reg(REG_INVERT_MASK, 32'h0);
			1: write_reg(REG_INVERT_MASK, 32'hFFFF);
			default: write_reg(REG_INVERT_MASK, DATA_W'($urandom_range(0, 16'hFFFF)));
		endcase
		write_reg(REG_EDGE_ENABLE, (idx % 5 == 4) ? 32'd0 : 32'd1);
		stall_pct = (idx % 4 == 0) ? 0 : $urandom_range(10, 60);
		steady = (idx % 4 == 1);
		r = PIN_W'($urandom);
		burst_left = 0;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (!steady && $urandom_range(0, 2) != 0)
					pause($urandom_range(1, 6));
			end
			burst_left--;
			r = next_raw(r);
			send_tick(r);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_priming();
		test_zero_debounce();
		test_retrigger();
		test_edges_disabled();
		test_channel_count();
		test_backpressure();
		for (int p = 0; p < RAND_PHASES; p++)
			test_random_phase(p);
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d ticks over %0d register writes; %0d results checked,",
			n_items, n_writes, n_results);
		$display("%0d with a level change, input held off for %0d cycles.",
			n_changes, input_stall_cycles);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", due_levels.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
